@@ rtl/core/idll_pkg.sv @@
`default_nettype none
package idll_pkg;

    localparam int OPCODE_W = 3;
    localparam int POS_W    = 8;
    localparam int DATA_W   = 64;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    localparam logic [OPCODE_W-1:0] OP_APPEND  = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_PREPEND = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_INSERT  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_REMOVE  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_READ    = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_WRITE   = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_CLEAR   = 3'd6;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    typedef logic [OPCODE_W-1:0] t_opcode;
    typedef logic [POS_W-1:0]    t_position;
    typedef logic [DATA_W-1:0]   t_data;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [COUNT_W-1:0]  t_count;

endpackage
`default_nettype wire

@@ rtl/core/idll_if.sv @@
`default_nettype none
interface idll_req_if;
    logic                 valid;
    logic                 ready;
    idll_pkg::t_opcode    opcode;
    idll_pkg::t_position  position;
    idll_pkg::t_data      data_in;

    modport source (output valid, output opcode, output position, output data_in,
                    input ready);
    modport sink   (input valid, input opcode, input position, input data_in,
                    output ready);
endinterface

interface idll_rsp_if;
    logic                 valid;
    logic                 ready;
    idll_pkg::t_data      data_out;
    idll_pkg::t_status    status;
    idll_pkg::t_count     count;

    modport source (output valid, output data_out, output status, output count,
                    input ready);
    modport sink   (input valid, input data_out, input status, input count,
                    output ready);
endinterface
`default_nettype wire

@@ rtl/core/indexed_doubly_linked_list.sv @@
// Indexed doubly linked list of up to CAPACITY values.
// Channels: i_req carries one request (opcode, position, data_in); o_rsp returns
// exactly one response per request (data_out, status, count after the request).
// One request is in flight at a time; i_req.ready is high only while the
// sequencer is idle and reset is released. A response waits in an output
// register, so a new request is taken while the previous response is still
// unclaimed.
// Path from the accept cycle to the response register, by opcode:
//   bad index, full, clear, unused opcode : straight to the response state
//   append, prepend, insert at either end : free stack read, link, response
//   read, write, remove, middle insert    : walk, access at the located slot,
//   then the op's own states and the response; the walk takes
//   min(idx, count-1-idx) hops, one link memory read each.
// The walk through the next/prev link memories is the long part. The next
// request is taken in the cycle after the response register loads, so no
// request is taken before the sequencer is through with the last one.
// Reset (synchronous, active low) empties the list and marks all slots free:
// the free stack uses a low-water mark, entries below it read as their own
// index, so no clearing pass is needed.
// When o_rsp stalls the finished response holds and the sequencer waits in its
// response state before taking the next request.
`default_nettype none
module indexed_doubly_linked_list #(
    parameter int CAPACITY   = 256,
    parameter int VALUE_BITS = 64
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    idll_req_if.sink       i_req,
    idll_rsp_if.source     o_rsp
);

    localparam int SW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > idll_pkg::POS_W) ? CW : idll_pkg::POS_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_TAKE  = 4'd1;   // free stack top read in flight
    localparam logic [3:0] S_LINK  = 4'd2;   // link new node at head or tail
    localparam logic [3:0] S_WALK  = 4'd3;   // one link hop per cycle
    localparam logic [3:0] S_OP    = 4'd4;   // reads at located slot; a write stores its value
    localparam logic [3:0] S_RD    = 4'd5;
    localparam logic [3:0] S_REM   = 4'd6;
    localparam logic [3:0] S_INS_A = 4'd7;   // write new node
    localparam logic [3:0] S_INS_B = 4'd8;   // patch neighbors
    localparam logic [3:0] S_RESP  = 4'd9;

    // slot memories
    logic [VALUE_BITS-1:0] r_val_mem  [CAPACITY];
    logic [SW-1:0]         r_next_mem [CAPACITY];
    logic [SW-1:0]         r_prev_mem [CAPACITY];
    logic [SW-1:0]         r_free_mem [CAPACITY];

    logic [VALUE_BITS-1:0] r_rd_val;
    logic [SW-1:0]         r_rd_next, r_rd_prev, r_rd_free;

    // list control
    logic [3:0]            r_state;
    logic [SW-1:0]         r_head, r_tail, r_cur, r_steps, r_before, r_new;
    logic [CW-1:0]         r_count, r_top, r_low;
    logic                  r_dir, r_pend, r_front;
    idll_pkg::t_opcode     r_op;
    logic [CMPW-1:0]       r_idx;
    logic [VALUE_BITS-1:0] r_v;
    idll_pkg::t_data       r_res_data;
    idll_pkg::t_status     r_res_status;

    // output register
    logic                  r_out_valid;
    idll_pkg::t_data       r_out_data;
    idll_pkg::t_status     r_out_status;
    idll_pkg::t_count      r_out_count;

    // memory ports
    logic                  w_val_we, w_next_we, w_prev_we, w_free_we;
    logic [SW-1:0]         w_val_wa, w_next_wa, w_prev_wa, w_free_wa;
    logic [VALUE_BITS-1:0] w_val_wd;
    logic [SW-1:0]         w_next_wd, w_prev_wd, w_free_wd;
    logic [SW-1:0]         w_link_ra, w_free_ra;

    logic [SW-1:0]         cur_eff, new_slot;
    logic [CW-1:0]         top_m1, cnt_m1;
    logic [CMPW-1:0]       idx_in, cnt_w, cnt_half, tail_steps;
    logic                  accept, full, out_free, is_head, is_tail;

    assign accept   = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE) && i_rst_n;
    assign full     = (r_count >= CAP_C);
    assign out_free = !r_out_valid || o_rsp.ready;

    assign idx_in     = CMPW'(i_req.position);
    assign cnt_w      = CMPW'(r_count);
    assign cnt_half   = cnt_w >> 1;
    assign tail_steps = cnt_w - CMPW'(1) - idx_in;
    assign cnt_m1     = r_count - CW'(1);
    assign is_head    = (r_idx == '0);
    assign is_tail    = (r_idx == CMPW'(cnt_m1));

    // walk address: freshly read link once a hop is in flight
    assign cur_eff  = r_pend ? (r_dir ? r_rd_prev : r_rd_next) : r_cur;

    // free stack pop: entries below the low-water mark were never overwritten
    assign top_m1   = r_top - CW'(1);
    assign w_free_ra = top_m1[SW-1:0];
    assign new_slot = (top_m1 < r_low) ? top_m1[SW-1:0] : r_rd_free;

    always_comb begin
        w_val_we  = 1'b0; w_val_wa  = new_slot; w_val_wd = r_v;
        w_next_we = 1'b0; w_next_wa = new_slot; w_next_wd = r_head;
        w_prev_we = 1'b0; w_prev_wa = new_slot; w_prev_wd = r_tail;
        w_free_we = 1'b0; w_free_wa = r_top[SW-1:0]; w_free_wd = r_cur;
        w_link_ra = (r_state == S_WALK) ? cur_eff : r_cur;
        case (r_state)
            S_LINK: begin
                w_val_we = 1'b1;
                if (r_count != '0) begin
                    if (r_front) begin
                        w_next_we = 1'b1;
                        w_prev_we = 1'b1; w_prev_wa = r_head; w_prev_wd = new_slot;
                    end else begin
                        w_prev_we = 1'b1;
                        w_next_we = 1'b1; w_next_wa = r_tail; w_next_wd = new_slot;
                    end
                end
            end
            S_OP: begin
                if (r_op == idll_pkg::OP_WRITE) begin
                    w_val_we = 1'b1; w_val_wa = r_cur;
                end
            end
            S_REM: begin
                w_prev_we = !is_tail; w_prev_wa = r_rd_next; w_prev_wd = r_rd_prev;
                w_next_we = !is_head; w_next_wa = r_rd_prev; w_next_wd = r_rd_next;
                w_free_we = 1'b1;
            end
            S_INS_A: begin
                w_val_we  = 1'b1;
                w_next_we = 1'b1; w_next_wd = r_cur;
                w_prev_we = 1'b1; w_prev_wd = r_rd_prev;
            end
            S_INS_B: begin
                w_next_we = 1'b1; w_next_wa = r_before; w_next_wd = r_new;
                w_prev_we = 1'b1; w_prev_wa = r_cur;    w_prev_wd = r_new;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_val_we) r_val_mem[w_val_wa] <= w_val_wd;
        r_rd_val <= r_val_mem[r_cur];
    end

    always_ff @(posedge i_clk) begin
        if (w_next_we) r_next_mem[w_next_wa] <= w_next_wd;
        r_rd_next <= r_next_mem[w_link_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_prev_we) r_prev_mem[w_prev_wa] <= w_prev_wd;
        r_rd_prev <= r_prev_mem[w_link_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_free_we) r_free_mem[w_free_wa] <= w_free_wd;
        r_rd_free <= r_free_mem[w_free_ra];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_top       <= CAP_C;
            r_low       <= CAP_C;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // the response state loads the register itself
            if (o_rsp.ready && (r_state != S_RESP)) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op         <= i_req.opcode;
                        r_idx        <= idx_in;
                        r_v          <= i_req.data_in[VALUE_BITS-1:0];
                        r_res_data   <= '0;
                        r_pend       <= 1'b0;
                        if (idx_in < cnt_half) begin
                            r_cur <= r_head; r_steps <= SW'(idx_in); r_dir <= 1'b0;
                        end else begin
                            r_cur <= r_tail; r_steps <= SW'(tail_steps); r_dir <= 1'b1;
                        end
                        case (i_req.opcode)
                            idll_pkg::OP_APPEND, idll_pkg::OP_PREPEND: begin
                                r_front <= (i_req.opcode == idll_pkg::OP_PREPEND);
                                if (full) begin
                                    r_res_status <= idll_pkg::ST_FULL;
                                    r_state      <= S_RESP;
                                end else begin
                                    r_res_status <= idll_pkg::ST_DONE;
                                    r_state      <= S_TAKE;
                                end
                            end
                            idll_pkg::OP_INSERT: begin
                                r_front <= (idx_in == '0);
                                if (idx_in > cnt_w) begin
                                    r_res_status <= idll_pkg::ST_BAD_INDEX;
                                    r_state      <= S_RESP;
                                end else if (full) begin
                                    r_res_status <= idll_pkg::ST_FULL;
                                    r_state      <= S_RESP;
                                end else if (idx_in == '0 || idx_in == cnt_w) begin
                                    r_res_status <= idll_pkg::ST_DONE;
                                    r_state      <= S_TAKE;
                                end else begin
                                    r_res_status <= idll_pkg::ST_DONE;
                                    r_state      <= S_WALK;
                                end
                            end
                            idll_pkg::OP_REMOVE, idll_pkg::OP_READ, idll_pkg::OP_WRITE: begin
                                if (idx_in >= cnt_w) begin
                                    r_res_status <= idll_pkg::ST_BAD_INDEX;
                                    r_state      <= S_RESP;
                                end else begin
                                    r_res_status <= idll_pkg::ST_DONE;
                                    r_state      <= S_WALK;
                                end
                            end
                            idll_pkg::OP_CLEAR: begin
                                r_head       <= '0;
                                r_tail       <= '0;
                                r_count      <= '0;
                                r_top        <= CAP_C;
                                r_low        <= CAP_C;
                                r_res_status <= idll_pkg::ST_DONE;
                                r_state      <= S_RESP;
                            end
                            default: begin
                                r_res_status <= idll_pkg::ST_DONE;
                                r_state      <= S_RESP;
                            end
                        endcase
                    end
                end
                S_TAKE: r_state <= S_LINK;
                S_LINK: begin
                    if (r_count == '0) begin
                        r_head <= new_slot; r_tail <= new_slot;
                    end else if (r_front) r_head <= new_slot;
                    else                  r_tail <= new_slot;
                    r_count <= r_count + CW'(1);
                    r_top   <= top_m1;
                    if (top_m1 < r_low) r_low <= top_m1;
                    r_state <= S_RESP;
                end
                S_WALK: begin
                    if (r_steps == '0) begin
                        r_cur   <= cur_eff;
                        r_state <= S_OP;
                    end else begin
                        r_pend  <= 1'b1;
                        r_steps <= r_steps - SW'(1);
                    end
                end
                S_OP: begin
                    case (r_op)
                        idll_pkg::OP_READ:   r_state <= S_RD;
                        idll_pkg::OP_REMOVE: r_state <= S_REM;
                        idll_pkg::OP_INSERT: r_state <= S_INS_A;
                        default:             r_state <= S_RESP;
                    endcase
                end
                S_RD: begin
                    r_res_data <= idll_pkg::DATA_W'(r_rd_val);
                    r_state    <= S_RESP;
                end
                S_REM: begin
                    if (cnt_m1 == '0) begin
                        r_head <= '0; r_tail <= '0;
                    end else begin
                        if (is_tail) r_tail <= r_rd_prev;
                        if (is_head) r_head <= r_rd_next;
                    end
                    r_count <= cnt_m1;
                    r_top   <= r_top + CW'(1);
                    r_state <= S_RESP;
                end
                S_INS_A: begin
                    r_before <= r_rd_prev;
                    r_new    <= new_slot;
                    r_count  <= r_count + CW'(1);
                    r_top    <= top_m1;
                    if (top_m1 < r_low) r_low <= top_m1;
                    r_state  <= S_INS_B;
                end
                S_INS_B: r_state <= S_RESP;
                S_RESP: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_data   <= r_res_data;
                        r_out_status <= r_res_status;
                        r_out_count  <= idll_pkg::COUNT_W'(r_count);
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.data_out = r_out_data;
    assign o_rsp.status   = r_out_status;
    assign o_rsp.count    = r_out_count;

    // list and free stack always partition the slots
    a_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count + r_top) == CAP_C)
        else $error("list count and free stack depth disagree");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("count above capacity");

    a_low_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low <= r_top)
        else $error("free stack low mark above top");

    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("sequencer idle right after a request");

endmodule
`default_nettype wire
